// ===== hdl/positional_list_engine_macros.svh =====
// Assertion shorthands shared by the engine's RTL.
// Every property samples on the rising edge of clock and is off while reset is high.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication.
`define PLE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ple_pkg.sv =====
`timescale 1ns / 1ps

package ple_pkg;

   // Fixed field widths of the command and result transfers.
   localparam int CMD_W  = 3;
   localparam int POS_W  = 7;
   localparam int VAL_W  = 32;
   localparam int ST_W   = 2;
   localparam int FPOS_W = 6;
   localparam int CNT_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ   = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_SEARCH = 3'd4
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

endpackage

// ===== hdl/ple_mem.sv =====
`timescale 1ns / 1ps

// Entry store: one write port, one read port, registered read data.
module ple_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ple_seq.sv =====
`timescale 1ns / 1ps
`include "positional_list_engine_macros.svh"

// Command sequencer: walks the entry store one read per cycle, moves entries
// through the single write port, compares for search, holds the result register.
module ple_seq #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ple_pkg::CMD_W-1:0]         req_command,
   input  logic [ple_pkg::POS_W-1:0]         req_position,
   input  logic signed [ple_pkg::VAL_W-1:0]  req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ple_pkg::ST_W-1:0]          rsp_status,
   output logic signed [ple_pkg::VAL_W-1:0]  rsp_read_value,
   output logic [ple_pkg::FPOS_W-1:0]        rsp_found_position,
   output logic [ple_pkg::CNT_W-1:0]         rsp_entry_count,
   output logic                              mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]       mem_wr_addr,
   output logic [DATA_WIDTH-1:0]             mem_wr_data,
   output logic                              mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]       mem_rd_addr,
   input  logic [DATA_WIDTH-1:0]             mem_rd_data
);

   import ple_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FIN
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]  val_ff, val_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   iss_ff, iss_in;
   logic                   pend_ff, pend_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [AW-1:0]          end_ff, end_in;
   logic [AW-1:0]          tag_ff, tag_in;
   status_type             status_ff, status_in;
   logic [DATA_WIDTH-1:0]  rd_ff, rd_in;
   logic [AW-1:0]          fpos_ff, fpos_in;
   logic                   wr_fin_ff, wr_fin_in;
   logic                   inc_ff, inc_in;
   logic                   dec_ff, dec_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]           rsp_status_ff, rsp_status_in;
   logic signed [VAL_W-1:0]   rsp_read_value_ff, rsp_read_value_in;
   logic [FPOS_W-1:0]         rsp_found_position_ff, rsp_found_position_in;
   logic [CNT_W-1:0]          rsp_entry_count_ff, rsp_entry_count_in;

   logic [XW-1:0] pos_x;
   logic [XW-1:0] cnt_x;
   logic [XW-1:0] cap_x;
   logic [AW-1:0] pos_a;
   logic [CW-1:0] cnt_m1;
   logic [AW-1:0] last_a;
   logic          in_range;
   logic          out_free;
   logic [CW-1:0] cnt_new;
   logic [XW-1:0] cnt_new_x;
   logic [XW-1:0] fpos_x;

   assign pos_x    = XW'(req_position);
   assign cnt_x    = XW'(count_ff);
   assign cap_x    = XW'(CAPACITY);
   assign pos_a    = pos_x[AW-1:0];
   assign cnt_m1   = count_ff - CW'(1);
   assign last_a   = cnt_m1[AW-1:0];
   assign in_range = (pos_x < cnt_x);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign cnt_new   = inc_ff ? (count_ff + CW'(1)) : (dec_ff ? cnt_m1 : count_ff);
   assign cnt_new_x = XW'(cnt_new);
   assign fpos_x    = XW'(fpos_ff);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      count_in  = count_ff;
      iss_in    = iss_ff;
      pend_in   = pend_ff;
      ptr_in    = ptr_ff;
      end_in    = end_ff;
      tag_in    = tag_ff;
      status_in = status_ff;
      rd_in     = rd_ff;
      fpos_in   = fpos_ff;
      wr_fin_in = wr_fin_ff;
      inc_in    = inc_ff;
      dec_in    = dec_ff;

      rsp_valid_in          = rsp_valid_ff;
      rsp_status_in         = rsp_status_ff;
      rsp_read_value_in     = rsp_read_value_ff;
      rsp_found_position_in = rsp_found_position_ff;
      rsp_entry_count_in    = rsp_entry_count_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = cmd_type'(req_command);
               pos_in    = pos_a;
               val_in    = DATA_WIDTH'(req_value);
               status_in = ST_OK;
               rd_in     = '0;
               fpos_in   = '0;
               wr_fin_in = 1'b0;
               inc_in    = 1'b0;
               dec_in    = 1'b0;
               iss_in    = 1'b0;
               pend_in   = 1'b0;
               state_in  = S_FIN;
               case (cmd_type'(req_command))
                  CMD_READ: begin
                     if (!in_range) begin
                        status_in = ST_RANGE;
                     end else begin
                        ptr_in   = pos_a;
                        end_in   = pos_a;
                        iss_in   = 1'b1;
                        state_in = S_WALK;
                     end
                  end
                  CMD_WRITE: begin
                     if (!in_range) begin
                        status_in = ST_RANGE;
                     end else begin
                        wr_fin_in = 1'b1;
                     end
                  end
                  CMD_INSERT: begin
                     if (pos_x > cnt_x) begin
                        status_in = ST_RANGE;
                     end else if (cnt_x == cap_x) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_fin_in = 1'b1;
                        inc_in    = 1'b1;
                        // shift the tail up, top entry first; append skips this
                        if (pos_x != cnt_x) begin
                           ptr_in   = last_a;
                           end_in   = pos_a;
                           iss_in   = 1'b1;
                           state_in = S_WALK;
                        end
                     end
                  end
                  CMD_REMOVE: begin
                     if (!in_range) begin
                        status_in = ST_RANGE;
                     end else begin
                        dec_in   = 1'b1;
                        ptr_in   = pos_a;
                        end_in   = last_a;
                        iss_in   = 1'b1;
                        state_in = S_WALK;
                     end
                  end
                  CMD_SEARCH: begin
                     status_in = ST_MISS;
                     if (count_ff != '0) begin
                        ptr_in   = '0;
                        end_in   = last_a;
                        iss_in   = 1'b1;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_WALK: begin
            // issue side: one read per cycle
            if (iss_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_ff;
               pend_in     = 1'b1;
               tag_in      = ptr_ff;
               if (ptr_ff == end_ff) begin
                  iss_in = 1'b0;
               end else if (cmd_ff == CMD_INSERT) begin
                  ptr_in = ptr_ff - AW'(1);
               end else begin
                  ptr_in = ptr_ff + AW'(1);
               end
            end else begin
               pend_in = 1'b0;
            end

            // data side: read issued last cycle is back
            if (pend_ff) begin
               if (!iss_ff) begin
                  state_in = S_FIN;
               end
               case (cmd_ff)
                  CMD_READ: begin
                     rd_in = mem_rd_data;
                  end
                  CMD_INSERT: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = tag_ff + AW'(1);
                     mem_wr_data = mem_rd_data;
                  end
                  CMD_REMOVE: begin
                     if (tag_ff == pos_ff) begin
                        rd_in = mem_rd_data;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = tag_ff - AW'(1);
                        mem_wr_data = mem_rd_data;
                     end
                  end
                  CMD_SEARCH: begin
                     if (mem_rd_data == val_ff) begin
                        status_in = ST_OK;
                        fpos_in   = tag_ff;
                        iss_in    = 1'b0;
                        pend_in   = 1'b0;
                        state_in  = S_FIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_FIN: begin
            // commit and load the result register together
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_status_in         = status_ff;
               rsp_read_value_in     = VAL_W'(signed'(rd_ff));
               rsp_found_position_in = fpos_x[FPOS_W-1:0];
               rsp_entry_count_in    = cnt_new_x[CNT_W-1:0];
               count_in              = cnt_new;
               if (wr_fin_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = pos_ff;
                  mem_wr_data = val_ff;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         iss_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         wr_fin_ff    <= 1'b0;
         inc_ff       <= 1'b0;
         dec_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
         wr_fin_ff    <= wr_fin_in;
         inc_ff       <= inc_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff                <= cmd_in;
      pos_ff                <= pos_in;
      val_ff                <= val_in;
      ptr_ff                <= ptr_in;
      end_ff                <= end_in;
      tag_ff                <= tag_in;
      status_ff             <= status_in;
      rd_ff                 <= rd_in;
      fpos_ff               <= fpos_in;
      rsp_status_ff         <= rsp_status_in;
      rsp_read_value_ff     <= rsp_read_value_in;
      rsp_found_position_ff <= rsp_found_position_in;
      rsp_entry_count_ff    <= rsp_entry_count_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_found_position = rsp_found_position_ff;
   assign rsp_entry_count    = rsp_entry_count_ff;

   `PLE_ASSERT_SAME(a_no_rw_clash, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr,
                    "entry move reads and writes the same address")
   `PLE_ASSERT_SAME(a_count_cap, 1'b1, count_ff <= CW'(CAPACITY), "count above capacity")
   `PLE_ASSERT_SAME(a_full_status, rsp_valid_ff && (rsp_status_ff == ST_FULL),
                    count_ff == CW'(CAPACITY), "full status with room left")
   `PLE_ASSERT_NEXT(a_insert_count, (state_ff == S_FIN) && out_free && inc_ff,
                    count_ff == $past(count_ff) + CW'(1), "insert did not grow count")
   `PLE_ASSERT_SAME(a_pend_follows_read, pend_ff, $past(mem_rd_en),
                    "read data slot without a read")

endmodule

// ===== hdl/positional_list_engine.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall  command, position, value
// rsp_      out        rsp_valid/rsp_stall  status, read_value, found_position, entry_count
//
// One command at a time; req_stall stays high from the transfer until the result is loaded.
// Read walks a single entry; overwrite, append, rejected and unknown commands and
// a search of an empty list go straight to commit. Other inserts and removes walk
// the entries between position and the end, and search walks until a hit or the end.
// Reset (synchronous) clears the count and the handshake state; store contents stay.
// A stalled result holds in the output register; a new command waits for it at commit.
module positional_list_engine #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ple_pkg::CMD_W-1:0]         req_command,
   input  logic [ple_pkg::POS_W-1:0]         req_position,
   input  logic signed [ple_pkg::VAL_W-1:0]  req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ple_pkg::ST_W-1:0]          rsp_status,
   output logic signed [ple_pkg::VAL_W-1:0]  rsp_read_value,
   output logic [ple_pkg::FPOS_W-1:0]        rsp_found_position,
   output logic [ple_pkg::CNT_W-1:0]         rsp_entry_count
);

   import ple_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   // sequencer <-> entry store
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   // Sequencer: decodes the command, checks range and fill, walks the store
   // (shift up for insert, shift down for remove, compare for search) and
   // drives the result register.
   ple_seq #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data)
   );

   // Entry store: CAPACITY words, contents undefined until written. Only
   // positions below the count are ever read back.
   ple_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
